### rtl/core/bicv_pkg.sv
// Shared types, constants and the CRC-32 byte update for the boot image validator.
package bicv_pkg;

  localparam logic [31:0] ImageMagic = 32'h4F54_4131;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam int unsigned MaxLenW    = 24;
  localparam int unsigned CntW       = 25;
  localparam logic [MaxLenW-1:0] MaxLenReset = 24'd131040;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_HDR_UNREAD   = 3'd1,
    VERDICT_NO_HEADER    = 3'd2,
    VERDICT_BAD_LENGTH   = 3'd3,
    VERDICT_PAY_UNREAD   = 3'd4,
    VERDICT_CRC_MISMATCH = 3'd5
  } verdict_e;

  typedef struct packed {
    logic       slot_start;
    logic [7:0] data_byte;
    logic       read_error;
  } item_t;

  typedef struct packed {
    logic        image_ok;
    verdict_e    verdict_code;
    logic [31:0] computed_crc;
    logic [31:0] image_length;
  } result_t;

  // reflected CRC-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/bicv_if.sv
// Stream channel interfaces: slot bytes in, verdict words out.
interface bicv_in_if;
  logic       valid;
  logic       ready;
  logic       slot_start;
  logic [7:0] data_byte;
  logic       read_error;

  modport source (output valid, output slot_start, output data_byte, output read_error,
                  input ready);
  modport sink (input valid, input slot_start, input data_byte, input read_error,
                output ready);
endinterface

interface bicv_out_if;
  logic        valid;
  logic        ready;
  logic        image_ok;
  logic [2:0]  verdict_code;
  logic [31:0] computed_crc;
  logic [31:0] image_length;

  modport source (output valid, output image_ok, output verdict_code,
                  output computed_crc, output image_length, input ready);
  modport sink (input valid, input image_ok, input verdict_code,
                input computed_crc, input image_length, output ready);
endinterface

### rtl/core/bicv_engine.sv
// Header parse, length check, payload CRC; one slot byte per cycle on fire_i.
module bicv_engine
  import bicv_pkg::*;
#(
  parameter int unsigned HeaderBytes = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  item_t              item_i,
  input  logic [MaxLenW-1:0] max_len_i,
  output logic               emit_o,
  output result_t            res_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  phase_e         phase_q, phase_d, cur_phase;
  logic [CntW-1:0] cnt_q, cnt_d, cur_cnt;
  logic [31:0]    magic_q, magic_d, cur_magic;
  logic [31:0]    len_q, len_d, cur_len;
  logic [31:0]    stored_q, stored_d, cur_stored;
  logic [31:0]    run_q, run_d, cur_run;
  logic           herr_q, herr_d, cur_herr;
  logic [1:0]     lane;

  assign lane = cur_cnt[1:0];

  always_comb begin
    // a slot start restarts from a clean header state before this byte
    cur_phase  = item_i.slot_start ? PH_HEADER : phase_q;
    cur_cnt    = item_i.slot_start ? '0 : cnt_q;
    cur_magic  = item_i.slot_start ? '0 : magic_q;
    cur_len    = item_i.slot_start ? '0 : len_q;
    cur_stored = item_i.slot_start ? '0 : stored_q;
    cur_run    = item_i.slot_start ? '1 : run_q;
    cur_herr   = item_i.slot_start ? 1'b0 : herr_q;

    phase_d  = cur_phase;
    cnt_d    = cur_cnt;
    magic_d  = cur_magic;
    len_d    = cur_len;
    stored_d = cur_stored;
    run_d    = cur_run;
    herr_d   = cur_herr;
    emit_o   = 1'b0;
    res_o    = '0;

    case (cur_phase)
      PH_HEADER: begin
        if (item_i.read_error) begin
          herr_d = 1'b1;
        end else if (cur_cnt < CntW'(12)) begin
          case (cur_cnt[3:2])
            2'd0:    magic_d[8*lane +: 8]  = item_i.data_byte;
            2'd1:    len_d[8*lane +: 8]    = item_i.data_byte;
            default: stored_d[8*lane +: 8] = item_i.data_byte;
          endcase
        end
        cnt_d = cur_cnt + CntW'(1);
        if (cur_cnt == CntW'(HeaderBytes - 1)) begin
          cnt_d  = '0;
          emit_o = 1'b1;
          res_o.computed_crc = ~cur_run;
          res_o.image_length = len_d;
          if (herr_d) begin
            res_o.verdict_code = VERDICT_HDR_UNREAD;
            res_o.image_length = '0;
          end else if (magic_d != ImageMagic) begin
            res_o.verdict_code = VERDICT_NO_HEADER;
          end else if (len_d == '0 || len_d > {{(32-MaxLenW){1'b0}}, max_len_i}) begin
            res_o.verdict_code = VERDICT_BAD_LENGTH;
          end else begin
            emit_o  = 1'b0;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (item_i.read_error) begin
          emit_o = 1'b1;
          res_o.verdict_code = VERDICT_PAY_UNREAD;
          res_o.computed_crc = ~cur_run;
          res_o.image_length = cur_len;
        end else begin
          run_d = crc_byte(cur_run, item_i.data_byte);
          cnt_d = cur_cnt + CntW'(1);
          if ({{(32-CntW){1'b0}}, cnt_d} >= cur_len) begin
            emit_o = 1'b1;
            res_o.computed_crc = ~run_d;
            res_o.image_length = cur_len;
            res_o.verdict_code = (~run_d == cur_stored) ? VERDICT_OK : VERDICT_CRC_MISMATCH;
            res_o.image_ok     = (~run_d == cur_stored);
          end
        end
      end
      default: ;
    endcase

    if (emit_o) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      magic_q  <= '0;
      len_q    <= '0;
      stored_q <= '0;
      run_q    <= '1;
      herr_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      magic_q  <= magic_d;
      len_q    <= len_d;
      stored_q <= stored_d;
      run_q    <= run_d;
      herr_q   <= herr_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && emit_o |=> phase_q == PH_DONE)
    else $error("verdict given but slot not closed");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> {{(32-CntW){1'b0}}, cnt_q} < len_q && len_q != '0)
    else $error("payload counter passed header length");

  a_ok_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.verdict_code == VERDICT_OK |->
      res_o.computed_crc == cur_stored && cur_phase == PH_PAYLOAD)
    else $error("valid verdict without matching CRC");
`endif

endmodule

### rtl/core/boot_image_crc_validator.sv
// Top level: input stage, validator engine, result register and config register.
//
//  channel | dir | handshake     | word
//  in_ch   | in  | valid/ready   | slot_start, data_byte, read_error
//  out_ch  | out | valid/ready   | image_ok, verdict_code, computed_crc, image_length
//  apb     | in  | psel/penable  | max_payload_length at address 0
//
// One byte word per cycle unless out_ch stalls; each verdict is registered.
// The engine's byte-wide CRC update sits between the input and result registers.
// Reset restores idle state and the default maximum length; no clearing pass.
// A stalled result holds the engine; the input register still takes one word.
module boot_image_crc_validator
  import bicv_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bicv_in_if.sink     in_ch,
  bicv_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               in_v_q;
  item_t              in_q;
  logic               out_v_q;
  result_t            out_q;
  logic [MaxLenW-1:0] max_len_q;
  logic               can_adv, fire, emit;
  result_t            res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-MaxLenW){1'b0}}, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_len_q <= pwdata[MaxLenW-1:0];
    end
  end

  assign can_adv     = !out_v_q || out_ch.ready;
  assign fire        = in_v_q && can_adv;
  assign in_ch.ready = !in_v_q || can_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= '{slot_start: in_ch.slot_start, data_byte: in_ch.data_byte,
                read_error: in_ch.read_error};
    end
  end

  bicv_engine #(
    .HeaderBytes(HEADER_BYTES)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .max_len_i (max_len_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (can_adv) begin
      out_v_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.image_ok     = out_q.image_ok;
  assign out_ch.verdict_code = out_q.verdict_code;
  assign out_ch.computed_crc = out_q.computed_crc;
  assign out_ch.image_length = out_q.image_length;

endmodule

### sim/tb_boot_image_crc_validator.sv
// Testbench for boot_image_crc_validator: slot streams, header and CRC verdicts, APB config.
`timescale 1ns / 100ps

module tb_boot_image_crc_validator;
  import bicv_pkg::*;

  localparam int unsigned HdrBytes   = 32;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned LongHold   = 300;

  typedef enum logic [1:0] {ST_IDLE, ST_HEADER, ST_PAYLOAD, ST_DONE} stage_e;

  typedef enum int {
    SK_GOOD, SK_MISMATCH, SK_HDR_ERR, SK_NO_HDR, SK_BAD_LEN, SK_PAY_ERR, SK_ABORT
  } slot_kind_e;

  // Tracks the validator state per accepted byte word and holds the verdicts due.
  class verdict_board;
    logic [23:0] max_len;
    stage_e      stage;
    logic [24:0] pos_cnt;
    logic [31:0] magic_w, len_w, crc_w, crc_acc;
    bit          hdr_err;
    result_t     due[$];
    int unsigned fails;
    int unsigned posted;

    function new();
      max_len = MaxLenReset;
      stage   = ST_IDLE;
      pos_cnt = '0;
      magic_w = '0;
      len_w   = '0;
      crc_w   = '0;
      crc_acc = '1;
      hdr_err = 1'b0;
      fails   = 0;
      posted  = 0;
    endfunction

    // LSB-first bit-serial form of the reflected CRC-32
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ (CrcPoly & {32{r[0] ^ b[i]}});
      end
      return r;
    endfunction

    function void post_verdict(verdict_e v, logic [31:0] len);
      result_t r;
      r.image_ok     = (v == VERDICT_OK);
      r.verdict_code = v;
      r.computed_crc = ~crc_acc;
      r.image_length = len;
      due.push_back(r);
      posted++;
      stage = ST_DONE;
    endfunction

    function void note_byte(item_t it);
      logic [24:0] pos;
      if (it.slot_start) begin
        stage   = ST_HEADER;
        pos_cnt = '0;
        magic_w = '0;
        len_w   = '0;
        crc_w   = '0;
        crc_acc = '1;
        hdr_err = 1'b0;
      end
      if (stage == ST_HEADER) begin
        pos = pos_cnt;
        if (it.read_error) begin
          hdr_err = 1'b1;
        end else if (pos < 12) begin
          case (pos[3:2])
            2'd0: magic_w |= 32'(it.data_byte) << (8 * pos[1:0]);
            2'd1: len_w   |= 32'(it.data_byte) << (8 * pos[1:0]);
            default: crc_w |= 32'(it.data_byte) << (8 * pos[1:0]);
          endcase
        end
        pos_cnt = pos_cnt + 1'b1;
        if (pos + 1 >= HdrBytes) begin
          pos_cnt = '0;
          // header error wins over every other header check, length reads as zero
          if (hdr_err) post_verdict(VERDICT_HDR_UNREAD, 32'd0);
          else if (magic_w != ImageMagic) post_verdict(VERDICT_NO_HEADER, len_w);
          else if (len_w == 0 || len_w > {8'd0, max_len}) post_verdict(VERDICT_BAD_LENGTH, len_w);
          else stage = ST_PAYLOAD;
        end
      end else if (stage == ST_PAYLOAD) begin
        if (it.read_error) begin
          post_verdict(VERDICT_PAY_UNREAD, len_w);
        end else begin
          crc_acc = crc_step(crc_acc, it.data_byte);
          pos_cnt = pos_cnt + 1'b1;
          if ({7'd0, pos_cnt} >= len_w)
            post_verdict((~crc_acc == crc_w) ? VERDICT_OK : VERDICT_CRC_MISMATCH, len_w);
        end
      end
    endfunction

    function void check_verdict(logic valid_bit, logic [2:0] code, logic [31:0] crc,
                                logic [31:0] len);
      result_t exp;
      if (due.size() == 0) begin
        $error("verdict word with none due: code %0d crc %h len %h", code, crc, len);
        fails++;
        return;
      end
      exp = due.pop_front();
      if (valid_bit !== exp.image_ok) begin
        $error("image_ok: expected %0d, got %0d", exp.image_ok, valid_bit);
        fails++;
      end
      if (code !== exp.verdict_code) begin
        $error("verdict_code: expected %0d, got %0d", exp.verdict_code, code);
        fails++;
      end
      if (crc !== exp.computed_crc) begin
        $error("computed_crc: expected %h, got %h", exp.computed_crc, crc);
        fails++;
      end
      if (len !== exp.image_length) begin
        $error("image_length: expected %h, got %h", exp.image_length, len);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bicv_in_if  in_ch ();
  bicv_out_if out_ch ();

  verdict_board sb = new();

  int unsigned src_idle;
  int unsigned sink_idle;
  int unsigned items_sent;
  bit          hold_pending;
  int unsigned hold_left;

  boot_image_crc_validator #(
    .HEADER_BYTES(HdrBytes)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_byte(input item_t it);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.slot_start <= it.slot_start;
    in_ch.data_byte  <= it.data_byte;
    in_ch.read_error <= it.read_error;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_byte(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic make_slot(input slot_kind_e kind, input logic [31:0] len);
    logic [7:0]  body[$];
    logic [31:0] acc, magic, stored;
    int          n_body, hdr_err_at, body_err_at, cut, k;
    item_t       it;
    acc         = '1;
    magic       = ImageMagic;
    hdr_err_at  = -1;
    body_err_at = -1;
    if (kind inside {SK_GOOD, SK_MISMATCH, SK_PAY_ERR, SK_ABORT}) n_body = int'(len);
    else n_body = $urandom_range(0, 3);
    for (k = 0; k < n_body; k++) begin
      body.push_back(8'($urandom));
      acc = verdict_board::crc_step(acc, body[k]);
    end
    stored = ~acc;
    case (kind)
      SK_MISMATCH: stored = stored ^ (32'd1 << $urandom_range(0, 31));
      SK_NO_HDR: begin
        if ($urandom_range(0, 1) != 0) magic = $urandom;
        else magic = ImageMagic ^ (32'd1 << $urandom_range(0, 31));
      end
      SK_HDR_ERR: hdr_err_at = $urandom_range(0, HdrBytes - 1);
      SK_PAY_ERR: body_err_at = HdrBytes + $urandom_range(0, n_body - 1);
      default: ;
    endcase
    if (kind == SK_ABORT) cut = $urandom_range(1, HdrBytes + n_body - 1);
    else cut = HdrBytes + n_body;
    for (k = 0; k < cut; k++) begin
      it.slot_start = (k == 0);
      it.read_error = (k == hdr_err_at) || (k == body_err_at)
                      || (kind == SK_HDR_ERR && $urandom_range(0, 7) == 0)
                      || (body_err_at >= 0 && k > body_err_at && $urandom_range(0, 1) != 0);
      if (k < 4) it.data_byte = magic[8*k +: 8];
      else if (k < 8) it.data_byte = len[8*(k-4) +: 8];
      else if (k < 12) it.data_byte = stored[8*(k-8) +: 8];
      else if (k < HdrBytes) it.data_byte = 8'($urandom);
      else it.data_byte = body[k-HdrBytes];
      drive_byte(it);
    end
    // trailing words land in the done state and must be dropped
    if (kind != SK_ABORT) begin
      repeat ($urandom_range(0, 2)) begin
        it.slot_start = 1'b0;
        it.data_byte  = 8'($urandom);
        it.read_error = 1'($urandom);
        drive_byte(it);
      end
    end
  endtask

  // Drop valid, let every due verdict drain, then give the pipeline time to empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_max_len(input logic [23:0] v);
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= '0;
    pwdata  <= {8'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.max_len = v;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {8'd0, v}) begin
      $error("max_payload_length: expected %h, got %h", {8'd0, v}, prdata);
      sb.fails++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned min_items, input int unsigned min_verdicts);
    int unsigned i0, v0;
    int          r;
    slot_kind_e  kind;
    logic [31:0] cap, len, lim;
    i0 = items_sent;
    v0 = sb.posted;
    while (items_sent - i0 < min_items || sb.posted - v0 < min_verdicts) begin
      r = $urandom_range(0, 99);
      if (r < 40) kind = SK_GOOD;
      else if (r < 55) kind = SK_MISMATCH;
      else if (r < 65) kind = SK_HDR_ERR;
      else if (r < 75) kind = SK_NO_HDR;
      else if (r < 85) kind = SK_BAD_LEN;
      else if (r < 95) kind = SK_PAY_ERR;
      else kind = SK_ABORT;
      cap = {8'd0, sb.max_len};
      if (kind == SK_BAD_LEN) begin
        case ($urandom_range(0, 3))
          0: len = 32'd0;
          1: len = cap + 1;
          2: len = $urandom | 32'h0100_0000;
          default: len = cap + 1 + $urandom_range(0, 1000);
        endcase
      end else if (kind == SK_HDR_ERR || kind == SK_NO_HDR) begin
        len = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(1, 12));
      end else begin
        lim = (cap < 12) ? cap : 32'd12;
        if (lim == 0) lim = 1;
        len = $urandom_range(1, lim);
        if (cap != 0 && $urandom_range(0, 9) == 0)
          len = $urandom_range(1, (cap < 200) ? cap : 32'd200);
        if (cap != 0 && cap <= 200 && $urandom_range(0, 7) == 0) len = cap;
      end
      make_slot(kind, len);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_pending) begin
      hold_left    = LongHold;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_verdict(out_ch.image_ok, out_ch.verdict_code, out_ch.computed_crc,
                       out_ch.image_length);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    item_t junk;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.slot_start = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.read_error = 1'b0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    src_idle         = 17;
    sink_idle        = 57;
    items_sent       = 0;
    hold_pending     = 1'b0;
    hold_left        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // words before any slot start are dropped while idle
    junk = '{slot_start: 1'b0, data_byte: 8'hFF, read_error: 1'b1};
    drive_byte(junk);
    junk = '{slot_start: 1'b0, data_byte: 8'h00, read_error: 1'b0};
    drive_byte(junk);
    make_slot(SK_GOOD, 32'd1);
    make_slot(SK_GOOD, 32'd5);
    make_slot(SK_MISMATCH, 32'd4);
    make_slot(SK_HDR_ERR, 32'd3);
    make_slot(SK_NO_HDR, 32'd3);
    make_slot(SK_BAD_LEN, 32'd0);
    make_slot(SK_BAD_LEN, 32'(MaxLenReset) + 1);
    make_slot(SK_PAY_ERR, 32'd6);
    make_slot(SK_ABORT, 32'd8);

    // length limit edges: at the limit, one above, a zero limit and the full 24-bit limit
    set_max_len(24'd1);
    make_slot(SK_GOOD, 32'd1);
    make_slot(SK_BAD_LEN, 32'd2);
    set_max_len(24'd0);
    make_slot(SK_BAD_LEN, 32'd1);
    set_max_len(24'hFF_FFFF);
    make_slot(SK_BAD_LEN, 32'h0100_0000);
    make_slot(SK_BAD_LEN, 32'hFFFF_FFFF);
    make_slot(SK_GOOD, 32'd7);

    set_max_len(MaxLenReset);
    run_random(40, 1);
    set_max_len(24'hFF_FFFF);
    run_random(40, 1);

    src_idle  = 57;
    sink_idle = 17;
    set_max_len(24'($urandom_range(1, 20)));
    run_random(40, 1);
    set_max_len(24'($urandom_range(1, 24'hFF_FFFF)));
    run_random(40, 1);

    src_idle  = 0;
    sink_idle = 0;
    set_max_len(24'd1);
    hold_pending = 1'b1;
    run_random(40, 1);
    set_max_len(MaxLenReset);
    run_random(40, 1);

    settle();
    if (sb.due.size() != 0) begin
      $error("%0d verdicts never arrived", sb.due.size());
      sb.fails++;
    end
    if (sb.fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/core/bicv_pkg.sv
rtl/core/bicv_if.sv
rtl/core/bicv_engine.sv
rtl/core/boot_image_crc_validator.sv
sim/tb_boot_image_crc_validator.sv
